@@ sv/lts_pkg.sv @@
// Package for the lexical token scanner: beat payload types, scan modes,
// token and error codes, and the fixed character table. No dependencies.
package lts_pkg;

  // Token kinds
  localparam logic [2:0] KindWord  = 3'd0;
  localparam logic [2:0] KindNum   = 3'd1;
  localparam logic [2:0] KindOper  = 3'd2;
  localparam logic [2:0] KindDelim = 3'd3;
  localparam logic [2:0] KindPunct = 3'd4;
  localparam logic [2:0] KindStr   = 3'd5;
  localparam logic [2:0] KindEnd   = 3'd6;
  localparam logic [2:0] KindErr   = 3'd7;

  // Error codes
  localparam logic [2:0] ErrNone    = 3'd0;
  localparam logic [2:0] ErrUnknown = 3'd1;
  localparam logic [2:0] ErrEofCmt  = 3'd2;
  localparam logic [2:0] ErrTooLong = 3'd3;
  localparam logic [2:0] ErrEofStr  = 3'd4;

  // Special bytes
  localparam logic [7:0] ChSlash   = 8'h2F;
  localparam logic [7:0] ChStar    = 8'h2A;
  localparam logic [7:0] ChQuote   = 8'h22;
  localparam logic [7:0] ChNewline = 8'h0A;

  // Saturation limits
  localparam logic [30:0] NumMax  = 31'h7FFF_FFFF;
  localparam logic [23:0] LineMax = 24'hFF_FFFF;

  typedef enum logic [3:0] {
    MODE_IDLE,
    MODE_WORD,
    MODE_NUM,
    MODE_OPER,
    MODE_STR,
    MODE_SLASH,
    MODE_LINECOM,
    MODE_BLOCK,
    MODE_BLOCKSTAR
  } scan_mode_e;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_input;
  } in_t;

  typedef struct packed {
    logic [2:0]  token_kind;
    logic [2:0]  error_code;
    logic [8:0]  token_length;
    logic [7:0]  first_char;
    logic [30:0] number_value;
    logic [23:0] line_number;
    logic        last_result;
  } res_t;

  typedef struct packed {
    logic ws;
    logic digit;
    logic alpha;
    logic start;
    logic oper;
    logic delim;
    logic punct;
  } char_class_t;

  // Classify one byte; newline is blank only when configured so
  function automatic char_class_t char_class(logic [7:0] c, logic nl_space);
    char_class_t cl;
    cl = '0;
    if (c >= "0" && c <= "9") begin
      cl.digit = 1'b1;
      cl.alpha = 1'b1;
    end else if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
                 c == "_" || c == "#") begin
      cl.alpha = 1'b1;
      cl.start = 1'b1;
    end else if (c == "$" || c == "'") begin
      cl.alpha = 1'b1;
    end else if (c == "+" || c == "/" || c == "-" || c == "*" || c == "\\" ||
                 c == ":" || c == "=" || c == "!" || c == "&" || c == "|" ||
                 c == "?" || c == "~") begin
      cl.oper = 1'b1;
    end else if (c == "<" || c == ">") begin
      cl.oper  = 1'b1;
      cl.delim = 1'b1;
    end else if (c == "{" || c == "[" || c == "(" || c == "}" || c == "]" ||
                 c == ")") begin
      cl.delim = 1'b1;
    end else if (c == ";" || c == "," || c == ".") begin
      cl.punct = 1'b1;
    end else if (c == " " || c == 8'h09) begin
      cl.ws = 1'b1;
    end else if (c == ChNewline) begin
      cl.ws = nl_space;
    end
    return cl;
  endfunction

  // Build one result beat; last_result is set later
  function automatic res_t make_res(logic [2:0] kind, logic [2:0] err, logic [8:0] len,
                                    logic [7:0] first, logic [30:0] num,
                                    logic [23:0] line);
    res_t r;
    r.token_kind   = kind;
    r.error_code   = err;
    r.token_length = len;
    r.first_char   = first;
    r.number_value = num;
    r.line_number  = line;
    r.last_result  = 1'b0;
    return r;
  endfunction

endpackage

@@ sv/lexical_token_scanner_top.sv @@
// Lexical token scanner top level: input register, scan state update and a
// four-entry result queue. Depends on lts_pkg.

// Takes one source byte (or an end-of-input mark) per input beat and returns
// word, number, operator, delimiter, punctuation, string, end and error
// tokens with length, first byte and line. An accepted byte is registered in
// the input register, then the scan state and up to two result beats are
// formed together from it and pushed into a four-entry result queue, which
// registers the results before they are offered. One byte is taken per cycle
// while each byte gives at most one result and the token channel keeps up; a
// byte that ends one token and starts another gives two beats, which leave
// through the result queue's single read port one after the other. Bytes are
// held off only while the queue has fewer than two free entries. The
// configuration write port (newline_is_space) is always ready; the user must
// write it only while the block is idle, which the block does not enforce.
module lexical_token_scanner_top
  import lts_pkg::*;
#(
  parameter int MAX_TOKEN = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_data_o,
  input  logic cfg_valid_i,
  output logic cfg_ready_o,
  input  logic cfg_newline_is_space_i
);

  localparam int CW = $clog2(MAX_TOKEN + 1);
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_TOKEN);

  // Token length field is nine bits wide; keep the low bits of the count
  function automatic logic [8:0] len9(logic [CW-1:0] x);
    logic [CW+8:0] w;
    w = {9'b0, x};
    return w[8:0];
  endfunction

  localparam logic [8:0] MaxLen = len9(MaxCnt);

  // Configuration register
  logic nl_space_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nl_space_q <= 1'b1;
    end else if (cfg_valid_i) begin
      nl_space_q <= cfg_newline_is_space_i;
    end
  end

  // Input register
  in_t  item_q;
  logic item_valid_q;
  logic proc;

  logic [2:0] q_cnt_q;

  assign proc       = item_valid_q && (q_cnt_q <= 3'd2);
  assign in_ready_o = !item_valid_q || proc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      item_valid_q <= 1'b1;
    end else if (proc) begin
      item_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_data_i;
    end
  end

  // Scan state
  scan_mode_e    mode_q, mode_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [23:0]   line_q, line_d;
  logic [30:0]   num_q, num_d;
  logic [7:0]    first_q, first_d;

  logic [7:0]  c;
  char_class_t cl;

  assign c  = item_q.char_byte;
  assign cl = char_class(c, nl_space_q);

  // Start scanning a byte between tokens (state as after clearing)
  scan_mode_e fr_mode;
  logic       fr_start;
  logic [3:0] fr_num;
  logic [7:0] fr_first;
  logic       fr_line_inc;
  logic       fr_emit;
  res_t       fr_res;

  always_comb begin
    fr_mode     = MODE_IDLE;
    fr_start    = 1'b0;
    fr_num      = 4'd0;
    fr_first    = 8'd0;
    fr_line_inc = 1'b0;
    fr_emit     = 1'b0;
    fr_res      = make_res(KindErr, ErrUnknown, 9'd1, c, 31'd0, line_q);
    priority if (cl.ws) begin
      fr_line_inc = (c == ChNewline);
    end else if (cl.punct) begin
      fr_emit = 1'b1;
      fr_res  = make_res(KindPunct, ErrNone, 9'd1, c, 31'd0, line_q);
    end else if (c == ChSlash) begin
      fr_mode = MODE_SLASH;
    end else if (c == ChQuote) begin
      fr_mode = MODE_STR;
    end else if (cl.start) begin
      fr_mode  = MODE_WORD;
      fr_start = 1'b1;
      fr_first = c;
    end else if (cl.digit) begin
      fr_mode  = MODE_NUM;
      fr_start = 1'b1;
      fr_first = c;
      fr_num   = c[3:0];
    end else if (cl.oper) begin
      fr_mode  = MODE_OPER;
      fr_start = 1'b1;
      fr_first = c;
    end else if (cl.delim) begin
      fr_emit = 1'b1;
      fr_res  = make_res(KindDelim, ErrNone, 9'd1, c, 31'd0, line_q);
    end else begin
      fr_emit = 1'b1;
    end
  end

  // Next decimal value, saturating
  logic [34:0] num_ext;
  logic [30:0] num_next;

  assign num_ext  = {4'b0, num_q} * 35'd10 + {31'b0, c[3:0]};
  assign num_next = (num_ext > {4'b0, NumMax}) ? NumMax : num_ext[30:0];

  // Step: state update and up to two results (a before b)
  logic   emit_a, emit_b;
  res_t   res_a, res_b;
  logic   line_inc;
  logic   too_long;
  logic   use_fresh;
  res_t   tok_res;
  logic [8:0] cur_len;

  assign too_long = (cnt_q >= MaxCnt);
  assign cur_len  = len9(cnt_q);

  always_comb begin
    mode_d    = mode_q;
    cnt_d     = cnt_q;
    num_d     = num_q;
    first_d   = first_q;
    line_inc  = 1'b0;
    emit_a    = 1'b0;
    emit_b    = 1'b0;
    res_a     = make_res(KindErr, ErrTooLong, MaxLen, first_q, 31'd0, line_q);
    res_b     = make_res(KindEnd, ErrNone, 9'd0, 8'd0, 31'd0, line_q);
    use_fresh = 1'b0;
    tok_res   = make_res(KindWord, ErrNone, cur_len, first_q, 31'd0, line_q);

    if (item_q.end_of_input) begin
      // Flush pending token, then end token
      emit_b = 1'b1;
      unique case (mode_q)
        MODE_WORD: begin
          emit_a = 1'b1;
          res_a  = tok_res;
        end
        MODE_NUM: begin
          emit_a = 1'b1;
          res_a  = make_res(KindNum, ErrNone, cur_len, first_q, num_q, line_q);
        end
        MODE_OPER: begin
          emit_a = 1'b1;
          res_a  = make_res(KindOper, ErrNone, cur_len, first_q, 31'd0, line_q);
        end
        MODE_SLASH: begin
          emit_a = 1'b1;
          res_a  = make_res(KindOper, ErrNone, 9'd1, ChSlash, 31'd0, line_q);
        end
        MODE_STR: begin
          emit_a = 1'b1;
          res_a  = make_res(KindErr, ErrEofStr, cur_len, first_q, 31'd0, line_q);
        end
        MODE_BLOCK, MODE_BLOCKSTAR: begin
          emit_a = 1'b1;
          res_a  = make_res(KindErr, ErrEofCmt, 9'd0, 8'd0, 31'd0, line_q);
        end
        default: ;
      endcase
      mode_d  = MODE_IDLE;
      cnt_d   = '0;
      num_d   = '0;
      first_d = '0;
    end else begin
      unique case (mode_q)
        MODE_WORD, MODE_OPER: begin
          if ((mode_q == MODE_WORD) ? cl.alpha : cl.oper) begin
            if (too_long) begin
              emit_a  = 1'b1;
              mode_d  = MODE_IDLE;
              cnt_d   = '0;
              num_d   = '0;
              first_d = '0;
            end else begin
              cnt_d = cnt_q + 1'b1;
            end
          end else begin
            emit_a    = 1'b1;
            res_a     = tok_res;
            res_a.token_kind = (mode_q == MODE_WORD) ? KindWord : KindOper;
            use_fresh = 1'b1;
          end
        end
        MODE_NUM: begin
          if (cl.digit) begin
            if (too_long) begin
              emit_a  = 1'b1;
              mode_d  = MODE_IDLE;
              cnt_d   = '0;
              num_d   = '0;
              first_d = '0;
            end else begin
              cnt_d = cnt_q + 1'b1;
              num_d = num_next;
            end
          end else begin
            emit_a    = 1'b1;
            res_a     = make_res(KindNum, ErrNone, cur_len, first_q, num_q, line_q);
            use_fresh = 1'b1;
          end
        end
        MODE_SLASH: begin
          priority if (c == ChSlash) begin
            mode_d = MODE_LINECOM;
          end else if (c == ChStar) begin
            mode_d = MODE_BLOCK;
          end else if (cl.oper) begin
            mode_d  = MODE_OPER;
            cnt_d   = CW'(2);
            first_d = ChSlash;
          end else begin
            emit_a    = 1'b1;
            res_a     = make_res(KindOper, ErrNone, 9'd1, ChSlash, 31'd0, line_q);
            use_fresh = 1'b1;
          end
        end
        MODE_STR: begin
          if (c == ChQuote) begin
            emit_a  = 1'b1;
            res_a   = make_res(KindStr, ErrNone, cur_len, first_q, 31'd0, line_q);
            mode_d  = MODE_IDLE;
            cnt_d   = '0;
            num_d   = '0;
            first_d = '0;
          end else if (too_long) begin
            emit_a  = 1'b1;
            mode_d  = MODE_IDLE;
            cnt_d   = '0;
            num_d   = '0;
            first_d = '0;
          end else begin
            cnt_d    = cnt_q + 1'b1;
            if (cnt_q == '0) begin
              first_d = c;
            end
            line_inc = (c == ChNewline);
          end
        end
        MODE_LINECOM: begin
          use_fresh = (c == ChNewline);
        end
        MODE_BLOCK: begin
          if (c == ChStar) begin
            mode_d = MODE_BLOCKSTAR;
          end else begin
            line_inc = (c == ChNewline);
          end
        end
        MODE_BLOCKSTAR: begin
          if (c == ChSlash) begin
            mode_d = MODE_IDLE;
          end else if (c != ChStar) begin
            mode_d   = MODE_BLOCK;
            line_inc = (c == ChNewline);
          end
        end
        default: begin
          use_fresh = 1'b1;
        end
      endcase

      // Rescan the byte as the start of a new token
      if (use_fresh) begin
        mode_d   = fr_mode;
        cnt_d    = fr_start ? CW'(1) : '0;
        num_d    = {27'b0, fr_num};
        first_d  = fr_first;
        line_inc = fr_line_inc;
        emit_b   = fr_emit;
        res_b    = fr_res;
      end
    end

    line_d = (line_inc && line_q != LineMax) ? line_q + 24'd1 : line_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      cnt_q   <= '0;
      line_q  <= 24'd1;
      num_q   <= '0;
      first_q <= '0;
    end else if (proc) begin
      mode_q  <= mode_d;
      cnt_q   <= cnt_d;
      line_q  <= line_d;
      num_q   <= num_d;
      first_q <= first_d;
    end
  end

  // Order the step's results and mark the last one
  res_t       push0, push1;
  logic [1:0] push_n;

  always_comb begin
    push0 = emit_a ? res_a : res_b;
    push1 = res_b;
    if (emit_a && emit_b) begin
      push1.last_result = 1'b1;
    end else begin
      push0.last_result = 1'b1;
    end
    push_n = proc ? ({1'b0, emit_a} + {1'b0, emit_b}) : 2'd0;
  end

  // Result queue
  res_t       res_q [4];
  logic [1:0] wr_ptr_q, rd_ptr_q;
  logic       pop;

  assign out_valid_o = (q_cnt_q != 3'd0);
  assign out_data_o  = res_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      q_cnt_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + push_n;
      rd_ptr_q <= rd_ptr_q + {1'b0, pop};
      q_cnt_q  <= q_cnt_q + {1'b0, push_n} - {2'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      res_q[wr_ptr_q] <= push0;
    end
    if (push_n == 2'd2) begin
      res_q[wr_ptr_q + 2'd1] <= push1;
    end
  end

endmodule

@@ tb/sv/lts_token_checker.sv @@
// Token checker for the lexical token scanner: watches the byte, token and
// config channels, predicts every token beat and compares it field by field.
// Depends on lts_pkg for the beat types, scan modes and codes.
module lts_token_checker
  import lts_pkg::*;
#(
  parameter int MaxToken = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_ready_i,
  input  in_t  in_data_i,
  input  logic out_valid_i,
  input  logic out_ready_i,
  input  res_t out_data_i,
  input  logic cfg_valid_i,
  input  logic cfg_ready_i,
  input  logic cfg_data_i,
  output int   fail_count_o,
  output int   pending_o
);

  localparam int PrintLimit = 40;

  // Character classes as this checker sees them
  typedef struct packed {
    logic blank;
    logic digit;
    logic alnum;
    logic start;
    logic op;
    logic delim;
    logic punct;
  } byte_sort_t;

  // Scanner state mirror
  scan_mode_e  mode_r   = MODE_IDLE;
  int unsigned tok_len  = 0;
  logic [23:0] line_r   = 24'd1;
  logic [30:0] acc_r    = '0;
  logic [7:0]  head_r   = '0;
  logic        nl_blank = 1'b1;

  res_t step_tokens[$];
  res_t tokens_due[$];
  res_t want;
  int   mismatches = 0;
  int   beats_seen = 0;

  assign fail_count_o = mismatches;

  function automatic byte_sort_t sort_byte(input logic [7:0] c, input logic nl);
    byte_sort_t k;
    k = '0;
    if (c >= "0" && c <= "9") begin
      k.digit = 1'b1;
      k.alnum = 1'b1;
    end else if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) begin
      k.alnum = 1'b1;
      k.start = 1'b1;
    end else begin
      case (c)
        "_", "#": begin
          k.alnum = 1'b1;
          k.start = 1'b1;
        end
        "$", "'": k.alnum = 1'b1;
        "+", "-", "*", "/", "\\", ":", "=", "!", "&", "|", "?", "~": k.op = 1'b1;
        // angle brackets are operators first, delimiters second
        "<", ">": begin
          k.op    = 1'b1;
          k.delim = 1'b1;
        end
        "{", "}", "[", "]", "(", ")": k.delim = 1'b1;
        ";", ",", ".": k.punct = 1'b1;
        " ", 8'h09: k.blank = 1'b1;
        ChNewline: k.blank = nl;
        default: ;
      endcase
    end
    return k;
  endfunction

  task automatic report(input string what);
    mismatches++;
    if (mismatches <= PrintLimit) $display("%0t: token beat %0d: %s", $time, beats_seen, what);
  endtask

  // Append one token to the tokens of the current byte
  task automatic add_token(input logic [2:0] kind, input logic [2:0] err,
                           input int unsigned len, input logic [7:0] first,
                           input logic [30:0] num);
    res_t r;
    r.token_kind   = kind;
    r.error_code   = err;
    r.token_length = 9'(len);
    r.first_char   = first;
    r.number_value = num;
    r.line_number  = line_r;
    r.last_result  = 1'b0;
    step_tokens.push_back(r);
  endtask

  task automatic count_line();
    if (line_r != LineMax) line_r = line_r + 24'd1;
  endtask

  task automatic drop_token();
    mode_r  = MODE_IDLE;
    tok_len = 0;
    acc_r   = '0;
    head_r  = '0;
  endtask

  task automatic open_token(input scan_mode_e m, input logic [7:0] c);
    mode_r  = m;
    tok_len = 1;
    head_r  = c;
  endtask

  // Scan a byte as if between tokens
  task automatic scan_fresh(input logic [7:0] c);
    byte_sort_t k;
    k = sort_byte(c, nl_blank);
    drop_token();
    if (k.blank) begin
      if (c == ChNewline) count_line();
    end else if (k.punct) begin
      add_token(KindPunct, ErrNone, 1, c, '0);
    end else if (c == ChSlash) begin
      mode_r = MODE_SLASH;
    end else if (c == ChQuote) begin
      mode_r = MODE_STR;
    end else if (k.start) begin
      open_token(MODE_WORD, c);
    end else if (k.digit) begin
      open_token(MODE_NUM, c);
      acc_r = 31'(c - "0");
    end else if (k.op) begin
      open_token(MODE_OPER, c);
    end else if (k.delim) begin
      add_token(KindDelim, ErrNone, 1, c, '0);
    end else begin
      add_token(KindErr, ErrUnknown, 1, c, '0);
    end
  endtask

  // Grow the current token; flag too long and drop it at the limit
  task automatic grow_token(output bit ok);
    if (tok_len >= MaxToken) begin
      add_token(KindErr, ErrTooLong, MaxToken, head_r, '0);
      drop_token();
      ok = 1'b0;
    end else begin
      tok_len++;
      ok = 1'b1;
    end
  endtask

  // Advance the scan by one byte beat and queue the tokens it yields
  task automatic scan_beat(input in_t item);
    logic [7:0]  c;
    byte_sort_t  k;
    bit          ok;
    logic [63:0] wide;
    c = item.char_byte;
    step_tokens.delete();
    if (item.end_of_input) begin
      case (mode_r)
        MODE_WORD:  add_token(KindWord, ErrNone, tok_len, head_r, '0);
        MODE_NUM:   add_token(KindNum, ErrNone, tok_len, head_r, acc_r);
        MODE_OPER:  add_token(KindOper, ErrNone, tok_len, head_r, '0);
        MODE_SLASH: add_token(KindOper, ErrNone, 1, ChSlash, '0);
        MODE_STR:   add_token(KindErr, ErrEofStr, tok_len, head_r, '0);
        MODE_BLOCK, MODE_BLOCKSTAR: add_token(KindErr, ErrEofCmt, 0, '0, '0);
        default: ;
      endcase
      add_token(KindEnd, ErrNone, 0, '0, '0);
      drop_token();
    end else begin
      k = sort_byte(c, nl_blank);
      case (mode_r)
        MODE_WORD: begin
          if (k.alnum) begin
            grow_token(ok);
          end else begin
            add_token(KindWord, ErrNone, tok_len, head_r, '0);
            scan_fresh(c);
          end
        end
        MODE_NUM: begin
          if (k.digit) begin
            grow_token(ok);
            if (ok) begin
              wide  = 64'(acc_r) * 64'd10 + 64'(c - "0");
              acc_r = (wide > 64'(NumMax)) ? NumMax : wide[30:0];
            end
          end else begin
            add_token(KindNum, ErrNone, tok_len, head_r, acc_r);
            scan_fresh(c);
          end
        end
        MODE_OPER: begin
          if (k.op) begin
            grow_token(ok);
          end else begin
            add_token(KindOper, ErrNone, tok_len, head_r, '0);
            scan_fresh(c);
          end
        end
        MODE_SLASH: begin
          if (c == ChSlash) begin
            mode_r = MODE_LINECOM;
          end else if (c == ChStar) begin
            mode_r = MODE_BLOCK;
          end else if (k.op) begin
            open_token(MODE_OPER, ChSlash);
            grow_token(ok);
          end else begin
            add_token(KindOper, ErrNone, 1, ChSlash, '0);
            scan_fresh(c);
          end
        end
        MODE_STR: begin
          if (c == ChQuote) begin
            add_token(KindStr, ErrNone, tok_len, head_r, '0);
            drop_token();
          end else begin
            grow_token(ok);
            if (ok) begin
              if (tok_len == 1) head_r = c;
              if (c == ChNewline) count_line();
            end
          end
        end
        MODE_LINECOM: begin
          // the closing newline is scanned again between tokens
          if (c == ChNewline) scan_fresh(c);
        end
        MODE_BLOCK: begin
          if (c == ChStar) mode_r = MODE_BLOCKSTAR;
          else if (c == ChNewline) count_line();
        end
        MODE_BLOCKSTAR: begin
          if (c == ChSlash) begin
            mode_r = MODE_IDLE;
          end else if (c != ChStar) begin
            mode_r = MODE_BLOCK;
            if (c == ChNewline) count_line();
          end
        end
        default: scan_fresh(c);
      endcase
    end
    if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last_result = 1'b1;
    foreach (step_tokens[i]) tokens_due.push_back(step_tokens[i]);
  endtask

  task automatic compare_token(input res_t got, input res_t exp_tok);
    if (got.token_kind !== exp_tok.token_kind)
      report($sformatf("token_kind %0d, want %0d", got.token_kind, exp_tok.token_kind));
    if (got.error_code !== exp_tok.error_code)
      report($sformatf("error_code %0d, want %0d", got.error_code, exp_tok.error_code));
    if (got.token_length !== exp_tok.token_length)
      report($sformatf("token_length %0d, want %0d", got.token_length, exp_tok.token_length));
    if (got.first_char !== exp_tok.first_char)
      report($sformatf("first_char %0h, want %0h", got.first_char, exp_tok.first_char));
    if (got.number_value !== exp_tok.number_value)
      report($sformatf("number_value %0d, want %0d", got.number_value, exp_tok.number_value));
    if (got.line_number !== exp_tok.line_number)
      report($sformatf("line_number %0d, want %0d", got.line_number, exp_tok.line_number));
    if (got.last_result !== exp_tok.last_result)
      report($sformatf("last_result %0b, want %0b", got.last_result, exp_tok.last_result));
  endtask

  // Track config, predict on byte beats, check token beats
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drop_token();
      line_r   = 24'd1;
      nl_blank = 1'b1;
      tokens_due.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) nl_blank = cfg_data_i;
      if (in_valid_i && in_ready_i) scan_beat(in_data_i);
      if (out_valid_i && out_ready_i) begin
        if (tokens_due.size() == 0) begin
          report("token beat with nothing expected");
        end else begin
          want = tokens_due.pop_front();
          compare_token(out_data_i, want);
        end
        beats_seen++;
      end
      pending_o <= tokens_due.size();
    end
  end

endmodule

@@ tb/sv/tb.sv @@
// Testbench top for the lexical token scanner: clock, reset, byte and config
// stimulus, token channel back-pressure, watchdog and verdict.
// Depends on lts_pkg, lexical_token_scanner_top and lts_token_checker.
module tb;
  import lts_pkg::*;

  localparam int    MaxToken      = 256;
  localparam int    RandomItems   = 360;
  localparam int    DrainCycles   = 8;
  localparam int    WatchdogLimit = 1000;
  localparam string WordHead      = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_#";
  localparam string WordTail      = "azAZ_#09$'";
  localparam string Digits        = "0123456789";
  localparam string Opers         = "+-*/\\:=!&|?~<>";
  localparam string LongOpers     = "+-=!&|<>";
  localparam string Delims        = "{}[]()<>";
  localparam string Puncts        = ";,.";
  localparam string Blanks        = " \t\n";
  localparam string StrText       = "ab Z7*/\n\t;";
  localparam string CmtText       = "ab /*\"x;";
  localparam string BlockText     = "ab*/\n \"";

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid    = 1'b0;
  in_t  in_data     = '0;
  logic out_ready   = 1'b0;
  logic cfg_valid   = 1'b0;
  logic cfg_data    = 1'b0;
  logic in_ready;
  logic out_valid;
  res_t out_data;
  logic cfg_ready;

  int   fail_count;
  int   pending;
  int   sent         = 0;
  int   stall_left   = 0;
  int   quiet_cycles = 0;
  int   phase;
  int   phase_target;
  bit   calm         = 1'b0;
  bit   gaps_on      = 1'b1;
  in_t  feed_q[$];

  always #6 clk_i = ~clk_i;

  lexical_token_scanner_top #(
    .MAX_TOKEN(MaxToken)
  ) DUT (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid),
    .in_ready_o            (in_ready),
    .in_data_i             (in_data),
    .out_valid_o           (out_valid),
    .out_ready_i           (out_ready),
    .out_data_o            (out_data),
    .cfg_valid_i           (cfg_valid),
    .cfg_ready_o           (cfg_ready),
    .cfg_newline_is_space_i(cfg_data)
  );

  lts_token_checker #(
    .MaxToken(MaxToken)
  ) token_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_data_i  (cfg_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // Stall the token channel in random bursts, none once calm
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (!calm && $urandom_range(0, 11) == 0) begin
      stall_left <= $urandom_range(0, 15);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Abort when no beat moves on any channel for too long
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WatchdogLimit) begin
      $display("[lexical_token_scanner_top] ERROR");
      $finish;
    end
  end

  function automatic logic [7:0] pick_char(input string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  task automatic queue_byte(input logic [7:0] b);
    feed_q.push_back('{char_byte: b, end_of_input: 1'b0});
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
  endtask

  // End mark; its byte is random and must be ignored
  task automatic queue_end();
    feed_q.push_back('{char_byte: 8'($urandom_range(0, 255)), end_of_input: 1'b1});
  endtask

  // Present one byte beat and hold it until taken, then maybe idle
  task automatic send_item(input in_t item);
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    sent++;
    if (!calm && gaps_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  endtask

  task automatic send_queued();
    gaps_on = ($urandom_range(0, 3) != 0);
    foreach (feed_q[i]) send_item(feed_q[i]);
    feed_q.delete();
  endtask

  // Hold off bytes until every token is back and the pipeline is empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_newline(input logic nl_blank);
    cfg_valid <= 1'b1;
    cfg_data  <= nl_blank;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // One random lexeme, mostly well formed, sometimes cut by an end mark
  task automatic queue_fragment();
    int pick;
    pick = $urandom_range(0, 11);
    case (pick)
      0, 1: begin
        queue_byte(pick_char(WordHead));
        repeat ($urandom_range(0, 7)) queue_byte(pick_char(WordTail));
      end
      2: repeat ($urandom_range(1, 12)) queue_byte(pick_char(Digits));
      3: repeat ($urandom_range(1, 4)) queue_byte(pick_char(Opers));
      4: queue_byte(pick_char(Delims));
      5: queue_byte(pick_char(Puncts));
      6: begin
        queue_byte(ChQuote);
        repeat ($urandom_range(0, 6)) queue_byte(pick_char(StrText));
        if ($urandom_range(0, 5) == 0) queue_end();
        else queue_byte(ChQuote);
      end
      7: begin
        queue_text("//");
        repeat ($urandom_range(0, 6)) queue_byte(pick_char(CmtText));
        queue_byte(ChNewline);
      end
      8: begin
        queue_text("/*");
        repeat ($urandom_range(0, 8)) queue_byte(pick_char(BlockText));
        if ($urandom_range(0, 5) == 0) queue_end();
        else queue_text("*/");
      end
      9: repeat ($urandom_range(1, 3)) queue_byte(pick_char(Blanks));
      10: repeat ($urandom_range(1, 3)) queue_byte(8'($urandom_range(0, 255)));
      default: queue_end();
    endcase
    // leave tokens adjacent half the time so one byte ends one and starts the next
    if ($urandom_range(0, 1) == 0) queue_byte(pick_char(Blanks));
  endtask

  // A token around the length limit, then an end mark to resync
  task automatic queue_long(input int which);
    int n;
    n = $urandom_range(MaxToken - 2, MaxToken + 3);
    case (which)
      0: begin
        queue_byte(pick_char(WordHead));
        repeat (n - 1) queue_byte(pick_char(WordTail));
      end
      1: repeat (n) queue_byte(pick_char(Digits));
      2: repeat (n) queue_byte(pick_char(LongOpers));
      default: begin
        queue_byte(ChQuote);
        repeat (n) queue_byte(pick_char(StrText));
        queue_byte(ChQuote);
      end
    endcase
    queue_end();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_newline(1'b1);

    // Directed: every token kind, comments, lone slash, byte extremes, end cases
    queue_text("x9$ 42<(,\"q\"/ /*a*/\n//\n7");
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_text("q");
    queue_end();
    queue_text("/*");
    queue_end();
    queue_text("\"a");
    queue_end();
    send_queued();

    // Random phases alternate the newline setting
    for (phase = 0; phase < 4; phase++) begin
      settle();
      set_newline(phase[0] == 1'b0);
      // one token around the length limit, some 260 beats on its own
      if (phase == 0) begin
        queue_long($urandom_range(0, 3));
        send_queued();
      end
      phase_target = sent + RandomItems / 4;
      while (sent < phase_target) begin
        if (phase == 3 && phase_target - sent < 80) calm = 1'b1;
        if ($urandom_range(0, 60) == 0) settle();
        queue_fragment();
        send_queued();
      end
    end

    calm = 1'b1;
    settle();
    if (fail_count == 0) $display("[lexical_token_scanner_top] OK");
    else $display("[lexical_token_scanner_top] ERROR");
    $finish;
  end

endmodule
